@@ design/sadt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short address device table package
// Table size, operation codes and status codes shared by the table core.
// ----------------------------------------------------------------------------
package sadt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [15:0] ADDR_FREE     = 16'h0000;
    localparam logic [15:0] ADDR_RESERVED = 16'hFFFF;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_ADD    = 2'd0;
    localparam t_func FUNC_LOOKUP = 2'd1;
    localparam t_func FUNC_SET    = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_INVALID  = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;

endpackage

@@ design/short_address_device_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short address device table core
// Scans the device table one entry per cycle up to the first match, then adds,
// looks up or updates the entry in a final cycle; a free or reserved address skips the scan.
// ----------------------------------------------------------------------------
// Timing: a free or reserved address goes from idle straight to the finishing
// state, which raises the strobe; any other address is scanned first, up to the
// first match or the last entry.
// Flow: one transaction at a time; start is taken only while idle.
// The receiver cannot stall.
// Reset: synchronous, active low; it empties the table and drops busy.
module short_address_device_table_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  sadt_pkg::t_func         i_func,
    input  logic [15:0]             i_short_addr,
    input  logic [63:0]             i_long_addr,
    output logic                    o_done,
    output sadt_pkg::t_status       o_status,
    output logic                    o_present,
    output logic [3:0]              o_slot,
    output logic [63:0]             o_stored_long_addr
);
    import sadt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_idx        r_idx;
    logic        r_match, r_free, r_invalid;
    t_idx        r_match_idx, r_free_idx;
    t_func       r_func;
    logic [15:0] r_addr;
    logic [63:0] r_laddr;

    logic [15:0] r_short_table [ENTRIES];
    logic [63:0] r_long_table  [ENTRIES];

    logic        hit, empty, last;
    logic [IDX_W+3:0] slot_ext;

    assign hit   = (r_short_table[r_idx] == r_addr);
    assign empty = (r_short_table[r_idx] == ADDR_FREE);
    assign last  = (r_idx == t_idx'(ENTRIES - 1));
    assign busy  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_short_addr == ADDR_FREE || i_short_addr == ADDR_RESERVED) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        slot_ext = '0;
        if (r_match) begin
            slot_ext = {4'b0000, r_match_idx};
        end else begin
            slot_ext = {4'b0000, r_free_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_match   <= 1'b0;
            r_free    <= 1'b0;
            r_invalid <= 1'b0;
            o_done    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_short_table[i] <= ADDR_FREE;
            end
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_idx     <= '0;
                        r_match   <= 1'b0;
                        r_free    <= 1'b0;
                        r_invalid <= (i_short_addr == ADDR_FREE) ||
                                     (i_short_addr == ADDR_RESERVED);
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_match <= 1'b1;
                    end
                    if (empty && !r_free) begin
                        r_free <= 1'b1;
                    end
                    if (!last) begin
                        r_idx <= r_idx + t_idx'(1);
                    end
                end
                S_FINISH: begin
                    o_done <= 1'b1;
                    if (!r_invalid && r_func == FUNC_ADD && !r_match && r_free) begin
                        r_short_table[r_free_idx] <= r_addr;
                    end
                end
                default: begin
                    o_done <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_func  <= i_func;
            r_addr  <= i_short_addr;
            r_laddr <= i_long_addr;
        end
        if (r_state == S_SCAN) begin
            if (hit) begin
                r_match_idx <= r_idx;
            end
            if (empty && !r_free) begin
                r_free_idx <= r_idx;
            end
        end
        if (r_state == S_FINISH && !r_invalid) begin
            if (r_func == FUNC_ADD && !r_match && r_free) begin
                r_long_table[r_free_idx] <= '0;
            end else if (r_func == FUNC_SET && r_match) begin
                r_long_table[r_match_idx] <= r_laddr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH) begin
            o_status           <= ST_OK;
            o_present          <= 1'b0;
            o_slot             <= '0;
            o_stored_long_addr <= '0;
            if (r_invalid) begin
                o_status <= ST_INVALID;
            end else if (r_match) begin
                o_present <= 1'b1;
                o_slot    <= slot_ext[3:0];
                if (r_func == FUNC_SET) begin
                    o_stored_long_addr <= r_laddr;
                end else begin
                    o_stored_long_addr <= r_long_table[r_match_idx];
                end
            end else if (r_func == FUNC_ADD) begin
                if (r_free) begin
                    o_present <= 1'b1;
                    o_slot    <= slot_ext[3:0];
                end else begin
                    o_status <= ST_FULL;
                end
            end else begin
                o_status <= ST_NOTFOUND;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FINISH))
        else $error("Result strobe without a finishing cycle.");

    a_ok_is_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK) |-> o_present)
        else $error("Successful transaction reports an absent address.");

    a_fail_is_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (!o_present && o_slot == 4'd0 &&
                                           o_stored_long_addr == 64'd0))
        else $error("Failed transaction carries entry data.");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");
`endif

endmodule
